// ----- src/rfsd_pkg.sv -----
// Shared types and constants for the rotating free-server dispatcher.
`default_nettype none
package rfsd_pkg;

  localparam int TIME_W     = 32;
  localparam int CFG_W      = 5;
  localparam logic [CFG_W-1:0] TOTAL_RESET = 5'd16;

  localparam int SRV_W      = 4;
  localparam int FLD_CNT_W  = 16;
  localparam int FLD_MASK_W = 16;

  localparam int IN_DATA_W  = 64;
  localparam int OUT_USED_W = SRV_W + 3 * FLD_CNT_W;
  localparam int OUT_DATA_W = 56;
  localparam int OUT_PAD_W  = OUT_DATA_W - OUT_USED_W;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [TIME_W-1:0] arrival;
    logic [TIME_W-1:0] end_time;
  } rfsd_entry_t;

  typedef struct packed {
    logic        valid;
    rfsd_entry_t entry;
  } rfsd_q_t;

  typedef enum logic [0:0] {
    BK_SEARCH,
    BK_COMMIT
  } rfsd_state_t;

endpackage
`default_nettype wire

// ----- src/rotating_free_server_dispatcher.sv -----
// Top level of the rotating free-server dispatcher: config register, front and back.
//
//  channel | direction | handshake            | payload
//  in_     | slave     | in_tvalid/in_tready  | in_tdata: arrival_time, work_length
//  out_    | master    | out_tvalid/out_tready| out_tdata: server, handled, top, mask;
//          |           |                      | out_tuser: dropped
//  cfg_    | slave     | cfg_valid/cfg_ready  | cfg_data: server_total
//
// Each request passes through the back end as a search, then a commit, with the
// search result registered ahead of the count and mask update; the front queue
// holds two beats so input accepts run ahead of the back end.
// Reset is synchronous, active low, and clears all timers and counts at once.
// A stalled output holds the back end in commit; the queue then fills and
// drops in_tready. cfg_ready is always high.
`default_nettype none
module rotating_free_server_dispatcher import rfsd_pkg::*; #(
  parameter int MAX_SERVERS = 16,
  parameter int COUNT_BITS  = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,   // [31:0] arrival_time, [63:32] work_length
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata,  // [3:0] assigned_server,
                                                 // [19:4] server_handled,
                                                 // [35:20] top_count,
                                                 // [51:36] busiest_mask, rest zero
  output logic                       out_tuser,  // [0] dropped
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_W-1:0]      cfg_data    // [4:0] server_total
);

  logic [CFG_W-1:0] total_r;
  rfsd_q_t          q;
  logic             q_ready;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= TOTAL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      total_r <= cfg_data;
    end
  end

  rfsd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_o       (q),
    .q_ready   (q_ready)
  );

  rfsd_back #(
    .MAX_SERVERS (MAX_SERVERS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .server_total (total_r),
    .q_i          (q),
    .q_ready      (q_ready),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tuser    (out_tuser)
  );

endmodule
`default_nettype wire

// ----- src/rfsd_front.sv -----
// Front end: accepts request beats, forms the saturated end time, queues them.
`default_nettype none
module rfsd_front import rfsd_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire logic [IN_DATA_W-1:0] in_tdata,   // [31:0] arrival_time, [63:32] work_length
  output rfsd_q_t                   q_o,
  input  wire logic                 q_ready
);

  rfsd_entry_t            slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]      cnt_r, cnt_nxt;
  logic [TIME_W:0]        sum;
  rfsd_entry_t            push_entry;
  logic                   push, pop;

  always_comb begin
    sum = {1'b0, in_tdata[TIME_W-1:0]} + {1'b0, in_tdata[2*TIME_W-1:TIME_W]};
    push_entry.arrival  = in_tdata[TIME_W-1:0];
    // saturate on carry out
    push_entry.end_time = sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
  end

  assign in_tready   = (cnt_r != QCNT_W'(QUEUE_DEPTH));
  assign push        = in_tvalid && in_tready;
  assign q_o.valid   = (cnt_r != '0);
  assign q_o.entry   = slot_r[rd_ptr_r];
  assign pop         = q_o.valid && q_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule
`default_nettype wire

// ----- src/rfsd_back.sv -----
// Back end: rotating free-server search, timer and count update, result register.
`default_nettype none
module rfsd_back import rfsd_pkg::*; #(
  parameter int MAX_SERVERS = 16,
  parameter int COUNT_BITS  = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic [CFG_W-1:0]      server_total,
  input  wire rfsd_q_t               q_i,
  output logic                       q_ready,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata,   // [3:0] assigned_server,
                                                  // [19:4] server_handled,
                                                  // [35:20] top_count,
                                                  // [51:36] busiest_mask, rest zero
  output logic                       out_tuser    // [0] dropped
);

  localparam int NW = $clog2(MAX_SERVERS + 1);
  localparam int TW = (NW > CFG_W) ? NW : CFG_W;
  localparam int SW = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
  localparam int MW = (MAX_SERVERS < FLD_MASK_W) ? MAX_SERVERS : FLD_MASK_W;
  localparam logic [COUNT_BITS-1:0] COUNT_LIMIT = {COUNT_BITS{1'b1}};

  rfsd_state_t           state_r, state_nxt;
  logic [TIME_W-1:0]     busy_r [MAX_SERVERS];
  logic [COUNT_BITS-1:0] cnt_r  [MAX_SERVERS];
  logic [COUNT_BITS-1:0] top_r;
  logic [SW-1:0]         slot_r;
  logic                  found_r;
  logic [SW-1:0]         pick_r;
  logic [TIME_W-1:0]     end_r;
  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic                  out_drop_r;

  logic [TW-1:0]          total_ext, n_c, start_inc;
  logic [SW-1:0]          start, slot_nxt;
  logic [MAX_SERVERS-1:0] free_v, upper_v;
  logic [SW-1:0]          pick_u, pick_l, pick;
  logic                   found;
  logic                   commit, out_free;
  logic [COUNT_BITS-1:0]  cnt_sel, cnt_inc, top_nxt;
  logic [COUNT_BITS-1:0]  cnt_new [MAX_SERVERS];
  logic [FLD_MASK_W-1:0]  mask_v;

  // clamp the server total to 1..MAX_SERVERS
  always_comb begin
    total_ext = TW'(server_total);
    if (total_ext == '0) begin
      n_c = TW'(1);
    end else if (total_ext > TW'(MAX_SERVERS)) begin
      n_c = TW'(MAX_SERVERS);
    end else begin
      n_c = total_ext;
    end
  end

  // search from the slot, wrapping to server 0
  always_comb begin
    start     = (TW'(slot_r) < n_c) ? slot_r : '0;
    start_inc = TW'(start) + TW'(1);
    slot_nxt  = (start_inc >= n_c) ? '0 : SW'(start_inc);
    pick_u    = '0;
    pick_l    = '0;
    for (int i = MAX_SERVERS - 1; i >= 0; i--) begin
      free_v[i]  = (busy_r[i] <= q_i.entry.arrival) && (TW'(i) < n_c);
      upper_v[i] = free_v[i] && (SW'(i) >= start);
      if (free_v[i]) begin
        pick_l = SW'(i);
      end
      if (upper_v[i]) begin
        pick_u = SW'(i);
      end
    end
    found = |free_v;
    pick  = (|upper_v) ? pick_u : pick_l;
  end

  // count update and busiest mask for the commit step
  always_comb begin
    cnt_sel = cnt_r[pick_r];
    cnt_inc = (cnt_sel == COUNT_LIMIT) ? cnt_sel : cnt_sel + COUNT_BITS'(1);
    top_nxt = (found_r && (cnt_inc > top_r)) ? cnt_inc : top_r;
    for (int i = 0; i < MAX_SERVERS; i++) begin
      cnt_new[i] = (found_r && (pick_r == SW'(i))) ? cnt_inc : cnt_r[i];
    end
    mask_v = '0;
    for (int i = 0; i < MW; i++) begin
      mask_v[i] = (cnt_new[i] == top_nxt) && (TW'(i) < n_c);
    end
    out_data_nxt = {
      {OUT_PAD_W{1'b0}},
      mask_v,
      FLD_CNT_W'(top_nxt),
      found_r ? FLD_CNT_W'(cnt_inc) : {FLD_CNT_W{1'b0}},
      found_r ? SRV_W'(pick_r) : {SRV_W{1'b0}}
    };
  end

  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_SEARCH: if (q_i.valid) state_nxt = BK_COMMIT;
      BK_COMMIT: if (out_free) state_nxt = BK_SEARCH;
      default:   state_nxt = BK_SEARCH;
    endcase
  end

  always_comb begin
    q_ready = 1'b0;
    commit  = 1'b0;
    unique case (state_r)
      BK_SEARCH: q_ready = 1'b1;
      BK_COMMIT: commit  = out_free;
      default: begin
        q_ready = 1'b0;
        commit  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_SEARCH;
      slot_r      <= '0;
      top_r       <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < MAX_SERVERS; i++) begin
        busy_r[i] <= '0;
        cnt_r[i]  <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (q_ready && q_i.valid) begin
        slot_r <= slot_nxt;
      end
      if (commit) begin
        top_r <= top_nxt;
        for (int i = 0; i < MAX_SERVERS; i++) begin
          cnt_r[i] <= cnt_new[i];
        end
        if (found_r) begin
          busy_r[pick_r] <= end_r;
        end
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_ready && q_i.valid) begin
      found_r <= found;
      pick_r  <= pick;
      end_r   <= q_i.entry.end_time;
    end
    if (commit) begin
      out_data_r <= out_data_nxt;
      out_drop_r <= !found_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_drop_r;

  a_pop_to_commit: assert property (@(posedge clk) disable iff (!rst_n)
    (q_ready && q_i.valid) |=> (state_r == BK_COMMIT))
    else $error("popped beat did not move to commit");

  a_pick_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_COMMIT && found_r) |-> (TW'(pick_r) < n_c))
    else $error("picked server outside the servers in use");

  a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    commit |=> out_tvalid)
    else $error("committed result not presented");

  a_top_monotone: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (top_r >= $past(top_r)))
    else $error("running top count decreased");

endmodule
`default_nettype wire
